// ===== sv/prim_mst_pkg.sv =====
// Shared types and constants for the Prim spanning tree unit.
// Holds the request and result formats and the control groups between modules.
// No dependencies.
`default_nettype none

package prim_mst_pkg;

    localparam int CMD_W           = 2;
    localparam int VERTEX_W        = 6;
    localparam int WEIGHT_W        = 16;
    localparam int NUM_NODES_W     = 7;
    localparam int DEF_MAX_NODES   = 64;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam logic [NUM_NODES_W-1:0] NUM_NODES_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RUN   = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_in_req;

    typedef struct packed {
        logic [VERTEX_W-1:0] parent_vertex;
        logic [VERTEX_W-1:0] child_vertex;
        logic                found;
        logic                last;
    } t_out_res;

    typedef struct packed {
        logic wt_we;
        logic row_we;
        logic row_clear;
    } t_graph_ctl;

    typedef struct packed {
        logic cost_we;
        logic flag_clear;
        logic tree_set;
    } t_best_ctl;

endpackage

`default_nettype wire

// ===== sv/prim_mst_graph.sv =====
// Graph store: weight memory and edge presence memory kept as one word per row.
// Each row has a valid bit, so a clear resets the valid bits instead of writing every row.
// Depends on prim_mst_pkg.
`default_nettype none

module prim_mst_graph #(
    parameter int MAX_NODES   = prim_mst_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = prim_mst_pkg::DEF_WEIGHT_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  prim_mst_pkg::t_graph_ctl     i_ctl,
    input  logic [$clog2(MAX_NODES)-1:0] i_wt_wrow,
    input  logic [$clog2(MAX_NODES)-1:0] i_wt_wcol,
    input  logic [WEIGHT_BITS-1:0]       i_wt_wdata,
    input  logic [$clog2(MAX_NODES)-1:0] i_wt_rrow,
    input  logic [$clog2(MAX_NODES)-1:0] i_wt_rcol,
    output logic [WEIGHT_BITS-1:0]       o_wt_rdata,
    input  logic [$clog2(MAX_NODES)-1:0] i_row_waddr,
    input  logic [MAX_NODES-1:0]         i_row_wdata,
    input  logic [$clog2(MAX_NODES)-1:0] i_row_raddr,
    output logic [MAX_NODES-1:0]         o_row_rdata
);
    import prim_mst_pkg::*;

    logic [WEIGHT_BITS-1:0] r_wt_mem [MAX_NODES][MAX_NODES];
    logic [WEIGHT_BITS-1:0] r_wt_rdata;
    logic [MAX_NODES-1:0]   r_row_mem [MAX_NODES];
    logic [MAX_NODES-1:0]   r_row_rdata;
    logic [MAX_NODES-1:0]   r_row_valid;
    logic                   r_row_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wt_we) begin
            r_wt_mem[i_wt_wrow][i_wt_wcol] <= i_wt_wdata;
        end
        r_wt_rdata <= r_wt_mem[i_wt_rrow][i_wt_rcol];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.row_we) begin
            r_row_mem[i_row_waddr] <= i_row_wdata;
        end
        r_row_rdata <= r_row_mem[i_row_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid  <= '0;
            r_row_rvalid <= 1'b0;
        end else begin
            r_row_rvalid <= r_row_valid[i_row_raddr];
            if (i_ctl.row_clear) begin
                r_row_valid <= '0;
            end else if (i_ctl.row_we) begin
                r_row_valid[i_row_waddr] <= 1'b1;
            end
        end
    end

    assign o_wt_rdata  = r_wt_rdata;
    assign o_row_rdata = r_row_rvalid ? r_row_rdata : '0;

endmodule

`default_nettype wire

// ===== sv/prim_mst_best.sv =====
// Candidate store: cheapest known link cost and parent of every vertex in a memory,
// with known and tree membership flags in flip-flops. Depends on prim_mst_pkg.
`default_nettype none

module prim_mst_best #(
    parameter int MAX_NODES   = prim_mst_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = prim_mst_pkg::DEF_WEIGHT_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  prim_mst_pkg::t_best_ctl      i_ctl,
    input  logic [$clog2(MAX_NODES)-1:0] i_rd_addr,
    output logic [WEIGHT_BITS-1:0]       o_rd_cost,
    output logic [$clog2(MAX_NODES)-1:0] o_rd_parent,
    output logic                         o_rd_known,
    output logic                         o_rd_tree,
    input  logic [$clog2(MAX_NODES)-1:0] i_wr_addr,
    input  logic [WEIGHT_BITS-1:0]       i_wr_cost,
    input  logic [$clog2(MAX_NODES)-1:0] i_wr_parent,
    input  logic [$clog2(MAX_NODES)-1:0] i_tree_addr
);
    import prim_mst_pkg::*;

    localparam int VIDX_W = $clog2(MAX_NODES);

    logic [WEIGHT_BITS+VIDX_W-1:0] r_mem [MAX_NODES];
    logic [WEIGHT_BITS+VIDX_W-1:0] r_rd_word;
    logic [MAX_NODES-1:0]          r_known;
    logic [MAX_NODES-1:0]          r_tree;
    logic                          r_rd_known;
    logic                          r_rd_tree;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cost_we) begin
            r_mem[i_wr_addr] <= {i_wr_cost, i_wr_parent};
        end
        r_rd_word <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known    <= '0;
            r_tree     <= '0;
            r_rd_known <= 1'b0;
            r_rd_tree  <= 1'b0;
        end else begin
            r_rd_known <= r_known[i_rd_addr];
            r_rd_tree  <= r_tree[i_rd_addr];
            if (i_ctl.flag_clear) begin
                r_known <= '0;
                r_tree  <= '0;
            end else begin
                if (i_ctl.cost_we) begin
                    r_known[i_wr_addr] <= 1'b1;
                end
                if (i_ctl.tree_set) begin
                    r_tree[i_tree_addr] <= 1'b1;
                end
            end
        end
    end

    assign o_rd_cost   = r_rd_word[WEIGHT_BITS+VIDX_W-1:VIDX_W];
    assign o_rd_parent = r_rd_word[VIDX_W-1:0];
    assign o_rd_known  = r_rd_known;
    assign o_rd_tree   = r_rd_tree;

endmodule

`default_nettype wire

// ===== sv/prim_minimum_spanning_tree_unit.sv =====
// Prim minimum spanning tree over an adjacency matrix held in on-chip memory.
// Reset needs no clearing pass. A clear request is done as it is accepted; a
// write-edge request writes both directions of the edge in turn, since both go
// through the single write port of the weight memory. A run request with n vertices
// (num_nodes saturated to MAX_NODES; no results for n below 2) produces n-1 results;
// each step that adds a vertex goes through ST_ROW, a ST_PASS scan of one row of the
// weight memory at one entry per cycle, ST_DRAIN and ST_EMIT. Once the graph is found
// disconnected each remaining result comes from ST_EMIT with no new scan. A result
// may wait in the output register while the next request is taken.
// Depends on prim_mst_pkg, prim_mst_graph and prim_mst_best.
`default_nettype none

module prim_minimum_spanning_tree_unit #(
    parameter int MAX_NODES   = prim_mst_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = prim_mst_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [prim_mst_pkg::NUM_NODES_W-1:0] i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  prim_mst_pkg::t_in_req                i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output prim_mst_pkg::t_out_res               o_out_data
);
    import prim_mst_pkg::*;

    localparam int VIDX_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_NODES);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_EDGE_A = 8'b0000_0010,
        ST_EDGE_B = 8'b0000_0100,
        ST_INIT   = 8'b0000_1000,
        ST_ROW    = 8'b0001_0000,
        ST_PASS   = 8'b0010_0000,
        ST_DRAIN  = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } t_state;

    t_state                 r_state, n_state;
    logic [NUM_NODES_W-1:0] r_num_nodes;
    logic [CNT_W-1:0]       r_n;
    logic [CNT_W-1:0]       r_step;
    logic [VIDX_W-1:0]      r_src;
    logic [VIDX_W-1:0]      r_j;
    logic                   r_p_valid;
    logic [VIDX_W-1:0]      r_p_j;
    logic                   r_have;
    logic [WEIGHT_BITS-1:0] r_low;
    logic [VIDX_W-1:0]      r_pick;
    logic [VIDX_W-1:0]      r_pick_par;
    logic [VIDX_W-1:0]      r_ea;
    logic [VIDX_W-1:0]      r_eb;
    logic [WEIGHT_BITS-1:0] r_ew;
    logic                   r_out_valid;
    t_out_res               r_out;

    logic                   in_acc;
    logic                   ends_ok;
    logic [CNT_W-1:0]       cfg_n;
    logic                   out_free;
    logic                   out_load;
    logic                   emit_last;

    t_graph_ctl             gctl;
    logic [VIDX_W-1:0]      row_raddr;
    logic [VIDX_W-1:0]      row_waddr;
    logic [MAX_NODES-1:0]   row_wdata;
    logic [MAX_NODES-1:0]   row_rdata;
    logic [VIDX_W-1:0]      wt_wrow;
    logic [VIDX_W-1:0]      wt_wcol;
    logic [WEIGHT_BITS-1:0] wt_rdata;

    t_best_ctl              bctl;
    logic [WEIGHT_BITS-1:0] best_cost;
    logic [VIDX_W-1:0]      best_parent;
    logic                   best_known;
    logic                   best_tree;

    logic                   p_upd;
    logic                   p_cand;
    logic                   p_better;
    logic [WEIGHT_BITS-1:0] p_cost;
    logic [VIDX_W-1:0]      p_par;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign ends_ok   = (int'(i_in_data.vertex_a) < MAX_NODES) &&
                       (int'(i_in_data.vertex_b) < MAX_NODES);
    assign cfg_n     = (int'(r_num_nodes) > MAX_NODES) ? MAX_N : CNT_W'(r_num_nodes);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_load  = (r_state == ST_EMIT) && out_free;
    assign emit_last = (r_step == r_n - CNT_W'(2));

    prim_mst_graph #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_graph (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (gctl),
        .i_wt_wrow   (wt_wrow),
        .i_wt_wcol   (wt_wcol),
        .i_wt_wdata  (r_ew),
        .i_wt_rrow   (r_src),
        .i_wt_rcol   (r_j),
        .o_wt_rdata  (wt_rdata),
        .i_row_waddr (row_waddr),
        .i_row_wdata (row_wdata),
        .i_row_raddr (row_raddr),
        .o_row_rdata (row_rdata)
    );

    prim_mst_best #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_best (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (bctl),
        .i_rd_addr   (r_j),
        .o_rd_cost   (best_cost),
        .o_rd_parent (best_parent),
        .o_rd_known  (best_known),
        .o_rd_tree   (best_tree),
        .i_wr_addr   (r_p_j),
        .i_wr_cost   (wt_rdata),
        .i_wr_parent (r_src),
        .i_tree_addr (r_src)
    );

    // Relaxation and minimum search share one pass over the row of the source vertex.
    always_comb begin
        p_upd    = r_p_valid && !best_tree && row_rdata[r_p_j] &&
                   (!best_known || (wt_rdata < best_cost));
        p_cost   = p_upd ? wt_rdata : best_cost;
        p_par    = p_upd ? r_src : best_parent;
        p_cand   = r_p_valid && !best_tree && (best_known || p_upd);
        p_better = p_cand && (!r_have || (p_cost < r_low));
    end

    always_comb begin
        n_state   = r_state;
        gctl      = '0;
        bctl      = '0;
        bctl.cost_we = p_upd;
        row_raddr = r_src;
        row_waddr = r_ea;
        row_wdata = row_rdata | (MAX_NODES'(1) << r_eb);
        wt_wrow   = r_ea;
        wt_wcol   = r_eb;
        unique case (r_state)
            ST_IDLE: begin
                row_raddr = VIDX_W'(i_in_data.vertex_a);
                if (in_acc) begin
                    unique case (i_in_data.cmd)
                        CMD_CLEAR: begin
                            gctl.row_clear = 1'b1;
                        end
                        CMD_WRITE: begin
                            if (ends_ok) begin
                                n_state = ST_EDGE_A;
                            end
                        end
                        CMD_RUN: begin
                            if (cfg_n >= CNT_W'(2)) begin
                                n_state = ST_INIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EDGE_A: begin
                row_raddr   = r_eb;
                gctl.row_we = 1'b1;
                gctl.wt_we  = 1'b1;
                n_state     = ST_EDGE_B;
            end
            ST_EDGE_B: begin
                row_waddr   = r_eb;
                row_wdata   = row_rdata | (MAX_NODES'(1) << r_ea);
                wt_wrow     = r_eb;
                wt_wcol     = r_ea;
                gctl.row_we = 1'b1;
                gctl.wt_we  = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_INIT: begin
                bctl.flag_clear = 1'b1;
                n_state         = ST_ROW;
            end
            ST_ROW: begin
                bctl.tree_set = 1'b1;
                n_state       = ST_PASS;
            end
            ST_PASS: begin
                if (r_j == VIDX_W'(r_n - CNT_W'(1))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end else if (r_have) begin
                        n_state = ST_ROW;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_num_nodes <= NUM_NODES_RESET;
            r_p_valid   <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= (r_state == ST_PASS);
            if (i_cfg_we) begin
                r_num_nodes <= i_cfg_wdata;
            end
            if (r_state == ST_ROW) begin
                r_have <= 1'b0;
            end else if (p_better) begin
                r_have <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && in_acc) begin
            r_ea <= VIDX_W'(i_in_data.vertex_a);
            r_eb <= VIDX_W'(i_in_data.vertex_b);
            r_ew <= WEIGHT_BITS'(i_in_data.edge_weight);
            r_n  <= cfg_n;
        end
        if (r_state == ST_INIT) begin
            r_src  <= '0;
            r_step <= '0;
        end
        if (r_state == ST_ROW) begin
            r_j <= VIDX_W'(1);
        end else if (r_state == ST_PASS) begin
            r_j <= r_j + VIDX_W'(1);
        end
        if (r_state == ST_PASS) begin
            r_p_j <= r_j;
        end
        if (p_better) begin
            r_low      <= p_cost;
            r_pick     <= r_p_j;
            r_pick_par <= p_par;
        end
        if (out_load) begin
            r_out.parent_vertex <= r_have ? VERTEX_W'(r_pick_par) : '0;
            r_out.child_vertex  <= r_have ? VERTEX_W'(r_pick) : '0;
            r_out.found         <= r_have;
            r_out.last          <= emit_last;
            r_step              <= r_step + CNT_W'(1);
            if (r_have) begin
                r_src <= r_pick;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_write_starts_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.cmd == CMD_WRITE) && ends_ok) |=> (r_state == ST_EDGE_A))
        else $error("edge write request did not start the row update");

    a_pick_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && r_have) |-> (r_pick != '0))
        else $error("root vertex selected as a new tree vertex");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |->
        ((r_out.parent_vertex == '0) && (r_out.child_vertex == '0)))
        else $error("not-found result carries nonzero vertices");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_PASS) || (r_state == ST_DRAIN) || (r_state == ST_EMIT)) |->
        ((r_step + CNT_W'(2)) <= r_n))
        else $error("step count ran past the end of the run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && emit_last) |=> (r_state == ST_IDLE))
        else $error("run continued after its final result");

endmodule

`default_nettype wire

// ===== tb/sv/prim_minimum_spanning_tree_unit_tb.sv =====
// Testbench for prim_minimum_spanning_tree_unit: clear, edge-write and run requests
// against an in-bench Prim predictor, with random idling on both channels.
// Depends on prim_mst_pkg and the unit under test.
`timescale 1ns / 1ps

module prim_minimum_spanning_tree_unit_tb;
    import prim_mst_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int NODES          = DEF_MAX_NODES;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_QUOTA    = 23;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [NUM_NODES_W-1:0] i_cfg_wdata = '0;
    logic                   i_in_valid  = 1'b0;
    t_in_req                i_in_data   = '0;
    logic                   i_out_stall = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_out_res               o_out_data;

    prim_minimum_spanning_tree_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_in_req  pending_requests[$];
    t_out_res tree_edges_due[$];

    bit                  link_known[NODES][NODES];
    logic [WEIGHT_W-1:0] link_weight[NODES][NODES];
    bit                  tree_member[NODES];
    bit                  cand_known[NODES];
    logic [WEIGHT_W-1:0] cand_cost[NODES];
    logic [VERTEX_W-1:0] cand_parent[NODES];
    int                  model_nodes = NUM_NODES_RESET;

    int send_idle_pct = 29;
    int recv_idle_pct = 69;
    int error_count   = 0;
    int items_queued  = 0;
    int requests_seen = 0;
    int runs_seen     = 0;
    int edges_checked = 0;
    int settings_used = 1;
    int idle_cycles   = 0;
    t_out_res due_edge;

    function void relax_row(input int src, input int n);
        for (int j = 1; j < n; j++) begin
            if (!tree_member[j] && link_known[src][j]) begin
                if (!cand_known[j] || link_weight[src][j] < cand_cost[j]) begin
                    cand_cost[j]   = link_weight[src][j];
                    cand_parent[j] = src[VERTEX_W-1:0];
                    cand_known[j]  = 1'b1;
                end
            end
        end
    endfunction

    function void predict_request(input t_in_req r);
        int                  n;
        bit                  have;
        int                  pick;
        logic [WEIGHT_W-1:0] low;
        t_out_res            res;
        case (r.cmd)
            CMD_CLEAR: begin
                for (int a = 0; a < NODES; a++)
                    for (int b = 0; b < NODES; b++)
                        link_known[a][b] = 1'b0;
            end
            CMD_WRITE: begin
                link_weight[r.vertex_a][r.vertex_b] = r.edge_weight;
                link_weight[r.vertex_b][r.vertex_a] = r.edge_weight;
                link_known[r.vertex_a][r.vertex_b]  = 1'b1;
                link_known[r.vertex_b][r.vertex_a]  = 1'b1;
            end
            CMD_RUN: begin
                runs_seen++;
                n = (model_nodes > NODES) ? NODES : model_nodes;
                if (n >= 2) begin
                    for (int j = 0; j < NODES; j++) begin
                        tree_member[j] = 1'b0;
                        cand_known[j]  = 1'b0;
                    end
                    tree_member[0] = 1'b1;
                    relax_row(0, n);
                    for (int step = 0; step + 1 < n; step++) begin
                        have = 1'b0;
                        pick = 0;
                        low  = '0;
                        for (int j = 1; j < n; j++) begin
                            if (!tree_member[j] && cand_known[j] &&
                                (!have || cand_cost[j] < low)) begin
                                have = 1'b1;
                                low  = cand_cost[j];
                                pick = j;
                            end
                        end
                        res.parent_vertex = have ? cand_parent[pick] : '0;
                        res.child_vertex  = have ? pick[VERTEX_W-1:0] : '0;
                        res.found         = have;
                        res.last          = (step + 2 == n);
                        if (have) begin
                            tree_member[pick] = 1'b1;
                            relax_row(pick, n);
                        end
                        tree_edges_due.push_back(res);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Request driver: the payload only moves on once the current request is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                requests_seen++;
                predict_request(i_in_data);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_data  <= pending_requests.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                edges_checked++;
                if (tree_edges_due.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Unexpected result: parent %0d child %0d found %0b last %0b",
                                 o_out_data.parent_vertex, o_out_data.child_vertex,
                                 o_out_data.found, o_out_data.last);
                end else begin
                    due_edge = tree_edges_due.pop_front();
                    if (o_out_data.parent_vertex !== due_edge.parent_vertex ||
                        o_out_data.child_vertex !== due_edge.child_vertex ||
                        o_out_data.found !== due_edge.found ||
                        o_out_data.last !== due_edge.last) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("Mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                     due_edge.parent_vertex, due_edge.child_vertex,
                                     due_edge.found, due_edge.last,
                                     o_out_data.parent_vertex, o_out_data.child_vertex,
                                     o_out_data.found, o_out_data.last);
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task queue_req(input logic [CMD_W-1:0] c, input int a, input int b, input int w);
        t_in_req r;
        r.cmd         = t_cmd'(c);
        r.vertex_a    = a[VERTEX_W-1:0];
        r.vertex_b    = b[VERTEX_W-1:0];
        r.edge_weight = w[WEIGHT_W-1:0];
        pending_requests.push_back(r);
        items_queued++;
    endtask

    function int pick_weight();
        case ($urandom_range(3))
            0:       return $urandom_range(3);
            1:       return 16'hFFFF - $urandom_range(1);
            default: return $urandom_range(16'hFFFF);
        endcase
    endfunction

    task wait_idle();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || tree_edges_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_nodes(input int v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v[NUM_NODES_W-1:0];
        model_nodes = v;
        settings_used++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task queue_random_phase(input int n, input int quota);
        int start;
        int edges;
        int child;
        int parent;
        start = items_queued;
        while (items_queued - start < quota) begin
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(2))
                    0: queue_req(CMD_UNUSED, $urandom_range(63), $urandom_range(63),
                                 $urandom_range(16'hFFFF));
                    1: queue_req(CMD_WRITE, $urandom_range(63), $urandom_range(63),
                                 pick_weight());
                    default: queue_req(CMD_CLEAR, $urandom_range(63), $urandom_range(63),
                                       $urandom_range(16'hFFFF));
                endcase
            end else begin
                if ($urandom_range(9) < 7)
                    queue_req(CMD_CLEAR, 0, 0, 0);
                edges = (n - 1 < 10) ? n - 1 : 10;
                for (int k = 1; k <= edges; k++) begin
                    child  = (n <= 11) ? k : $urandom_range(n - 1, 1);
                    parent = $urandom_range(child - 1, 0);
                    if ($urandom_range(9) != 0) begin
                        if ($urandom_range(1))
                            queue_req(CMD_WRITE, parent, child, pick_weight());
                        else
                            queue_req(CMD_WRITE, child, parent, pick_weight());
                    end
                end
                if (n >= 2)
                    repeat ($urandom_range(2))
                        queue_req(CMD_WRITE, $urandom_range(n - 1), $urandom_range(n - 1),
                                  pick_weight());
                queue_req(CMD_RUN, $urandom_range(63), $urandom_range(63),
                          $urandom_range(16'hFFFF));
            end
        end
    endtask

    int phase_nodes[NUM_PHASES] = '{3, 64, 5, 2, 127, 8, 4, 12};

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset node count, extreme endpoints and weights, a self loop, the unused command.
        queue_req(CMD_CLEAR, 0, 0, 0);
        queue_req(CMD_WRITE, 0, 63, 16'hFFFF);
        queue_req(CMD_WRITE, 63, 1, 0);
        queue_req(CMD_WRITE, 2, 2, 7);
        queue_req(CMD_WRITE, 0, 2, 16'h8000);
        queue_req(CMD_UNUSED, 63, 63, 16'hFFFF);
        queue_req(CMD_RUN, 0, 0, 0);

        // Equal costs go to the lowest vertex, and a later equal link does not replace.
        write_nodes(4);
        queue_req(CMD_CLEAR, 0, 0, 0);
        queue_req(CMD_WRITE, 0, 1, 5);
        queue_req(CMD_WRITE, 0, 2, 5);
        queue_req(CMD_WRITE, 1, 3, 9);
        queue_req(CMD_WRITE, 2, 3, 9);
        queue_req(CMD_RUN, 0, 0, 0);
        queue_req(CMD_WRITE, 0, 1, 3);
        queue_req(CMD_WRITE, 3, 2, 2);
        queue_req(CMD_RUN, 0, 0, 0);

        write_nodes(0);
        queue_req(CMD_RUN, 0, 0, 0);
        write_nodes(1);
        queue_req(CMD_RUN, 0, 0, 0);

        // Node count above the limit, with vertex 0 cut off from the only edge.
        write_nodes(127);
        queue_req(CMD_CLEAR, 0, 0, 0);
        queue_req(CMD_WRITE, 63, 62, 1);
        queue_req(CMD_RUN, 0, 0, 0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_nodes(phase_nodes[p]);
            if (p < 3) begin
                send_idle_pct = 29;
                recv_idle_pct = 69;
            end else if (p < 6) begin
                send_idle_pct = 69;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_random_phase((phase_nodes[p] > NODES) ? NODES : phase_nodes[p], PHASE_QUOTA);
        end

        wait_idle();
        $display("Covered %0d requests with %0d runs over %0d node-count settings.",
                 requests_seen, runs_seen, settings_used);
        $display("Checked %0d tree edge results, %0d errors.", edges_checked, error_count);
        if (error_count == 0 && tree_edges_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
